// File: rtl/dset_pkg.sv
// ---------------------------------------------------------------------------
// dset_pkg
// Shared types and constants for the date sorted entry table: table size,
// operation and status codes, and the command bundle that the controller
// sends to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package dset_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATE_W      = 32;
    localparam int ID_W        = 16;
    localparam int OUT_CNT_W   = 7;

    typedef enum logic [1:0] {
        MODE_INSERT    = 2'd0,
        MODE_POP_FIRST = 2'd1,
        MODE_POP_LAST  = 2'd2,
        MODE_LOOKUP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_req;   // capture the accepted request
        logic compare;    // evaluate all cells against the request
        logic apply;      // update the cells and load the result register
    } dset_cmd_t;

endpackage

`default_nettype wire

// File: rtl/date_sorted_entry_table.sv
// ---------------------------------------------------------------------------
// date_sorted_entry_table
// Bounded table of (date, id) entries, newest date first and larger id first
// on equal dates. Supports insert, remove first, remove last and lookup.
//
//   Channel   Signals                                  Direction  Handshake
//   request   mode, date_key, entry_id                 in         req_valid / req_stall
//   response  status, found, latest_date, entry_count, out        rsp_valid / rsp_stall
//             head_id, head_date
//
// Each request runs a compare phase, checking it against every cell in
// parallel, then an apply phase that updates the cells and loads the result register.
// A new request is taken in the same cycle the previous result is loaded.
// Reset clears the entry count; cell contents are not reset.
// A stalled response holds the apply phase until the result register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module date_sorted_entry_table
    import dset_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [1:0]          mode,
    input  wire logic [DATE_W-1:0]   date_key,
    input  wire logic [ID_W-1:0]     entry_id,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic [1:0]               status,
    output logic                     found,
    output logic [DATE_W-1:0]        latest_date,
    output logic [OUT_CNT_W-1:0]     entry_count,
    output logic [ID_W-1:0]          head_id,
    output logic [DATE_W-1:0]        head_date
);

    dset_cmd_t cmd;

    dset_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    dset_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .date_key    (date_key),
        .entry_id    (entry_id),
        .status      (status),
        .found       (found),
        .latest_date (latest_date),
        .entry_count (entry_count),
        .head_id     (head_id),
        .head_date   (head_date)
    );

endmodule

`default_nettype wire

// File: rtl/dset_ctrl.sv
// ---------------------------------------------------------------------------
// dset_ctrl
// Controller for the sorted table: sequences compare and apply phases and
// owns both handshakes and the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module dset_ctrl
    import dset_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output dset_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        apply_fire;
    logic        accept;

    // Apply only when the result register is free or being emptied
    assign apply_fire = (state_reg == S_APPLY) && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = !((state_reg == S_IDLE) || apply_fire);
    assign accept     = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_fire)
                    state_next = accept ? S_CMP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs to the datapath
    always_comb
    begin
        cmd.load_req = accept;
        cmd.compare  = (state_reg == S_CMP);
        cmd.apply    = apply_fire;
    end

    // Result valid: set on apply, drop when taken
    always_comb
    begin
        if (apply_fire)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dset_datapath.sv
// ---------------------------------------------------------------------------
// dset_datapath
// Row of sorted cells with per-cell comparators, request capture, entry
// count and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module dset_datapath
    import dset_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dset_cmd_t           cmd,
    input  wire logic [1:0]          mode,
    input  wire logic [DATE_W-1:0]   date_key,
    input  wire logic [ID_W-1:0]     entry_id,
    output logic [1:0]               status,
    output logic                     found,
    output logic [DATE_W-1:0]        latest_date,
    output logic [OUT_CNT_W-1:0]     entry_count,
    output logic [ID_W-1:0]          head_id,
    output logic [DATE_W-1:0]        head_date
);

    // Request capture
    mode_t               mode_reg;
    logic [DATE_W-1:0]   date_reg;
    logic [ID_W-1:0]     id_reg;

    // Cell row and count
    logic [DATE_W-1:0]   cell_date_reg [TABLE_DEPTH];
    logic [ID_W-1:0]     cell_id_reg   [TABLE_DEPTH];
    logic [DATE_W-1:0]   cell_date_next [TABLE_DEPTH];
    logic [ID_W-1:0]     cell_id_next   [TABLE_DEPTH];
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    occ_next;

    // Compare flags
    logic [TABLE_DEPTH-1:0] after_reg;
    logic [TABLE_DEPTH-1:0] after_next;
    logic [TABLE_DEPTH-1:0] hit;
    logic [TABLE_DEPTH-1:0] first_hit_reg;
    logic [TABLE_DEPTH-1:0] first_hit_next;
    logic [TABLE_DEPTH-1:0] prev_after;

    // Result
    status_t             status_next;
    logic                found_next;
    logic [DATE_W-1:0]   latest_next;
    logic [DATE_W-1:0]   hit_date;
    logic                is_full;
    logic                is_empty;

    status_t             status_reg;
    logic                found_reg;
    logic [DATE_W-1:0]   latest_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [ID_W-1:0]     head_id_reg;
    logic [DATE_W-1:0]   head_date_reg;

    // Capture request
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg <= mode_t'(mode);
            date_reg <= date_key;
            id_reg   <= entry_id;
        end
    end

    // Compare the request against every occupied cell
    always_comb
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            after_next[k] = (CNT_W'(k) < occ_reg) &&
                            ({date_reg, id_reg} <= {cell_date_reg[k], cell_id_reg[k]});
            hit[k]        = (CNT_W'(k) < occ_reg) && (cell_id_reg[k] == id_reg);
        end
        // Newest date for an id sits at its lowest matching cell
        first_hit_next = hit & (~hit + 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            after_reg     <= after_next;
            first_hit_reg <= first_hit_next;
        end
    end

    assign is_full    = (occ_reg == CNT_W'(TABLE_DEPTH));
    assign is_empty   = (occ_reg == '0);
    assign prev_after = {after_reg[TABLE_DEPTH-2:0], 1'b1};

    // Next cell contents
    always_comb
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            cell_date_next[k] = cell_date_reg[k];
            cell_id_next[k]   = cell_id_reg[k];
            case (mode_reg)
                MODE_INSERT:
                begin
                    if (!is_full && !after_reg[k])
                    begin
                        if (prev_after[k])
                        begin
                            cell_date_next[k] = date_reg;
                            cell_id_next[k]   = id_reg;
                        end
                        else if (k > 0)
                        begin
                            cell_date_next[k] = cell_date_reg[(k > 0) ? k - 1 : 0];
                            cell_id_next[k]   = cell_id_reg[(k > 0) ? k - 1 : 0];
                        end
                    end
                end
                MODE_POP_FIRST:
                begin
                    if (!is_empty && (k < TABLE_DEPTH - 1))
                    begin
                        cell_date_next[k] = cell_date_reg[(k < TABLE_DEPTH - 1) ? k + 1 : k];
                        cell_id_next[k]   = cell_id_reg[(k < TABLE_DEPTH - 1) ? k + 1 : k];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            for (int k = 0; k < TABLE_DEPTH; k++)
            begin
                cell_date_reg[k] <= cell_date_next[k];
                cell_id_reg[k]   <= cell_id_next[k];
            end
        end
    end

    // Select the date of the first matching cell
    always_comb
    begin
        hit_date = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if (first_hit_reg[k])
                hit_date = hit_date | cell_date_reg[k];
        end
    end

    // Count and status
    always_comb
    begin
        occ_next    = occ_reg;
        status_next = ST_DONE;
        found_next  = 1'b0;
        latest_next = '0;
        case (mode_reg)
            MODE_INSERT:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                    occ_next = occ_reg + 1'b1;
            end
            MODE_POP_FIRST, MODE_POP_LAST:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                    occ_next = occ_reg - 1'b1;
            end
            MODE_LOOKUP:
            begin
                found_next  = |first_hit_reg;
                latest_next = hit_date;
                if (!found_next)
                    status_next = ST_ABSENT;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (cmd.apply)
            occ_reg <= occ_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            latest_reg    <= latest_next;
            count_reg     <= occ_next;
            head_id_reg   <= (occ_next == '0) ? '0 : cell_id_next[0];
            head_date_reg <= (occ_next == '0) ? '0 : cell_date_next[0];
        end
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign latest_date = latest_reg;
    assign entry_count = OUT_CNT_W'(count_reg);
    assign head_id     = head_id_reg;
    assign head_date   = head_date_reg;

endmodule

`default_nettype wire

// File: rtl/dset_checker.sv
// ---------------------------------------------------------------------------
// dset_checker
// Port-level checks on the response channel of the sorted entry table.
// ---------------------------------------------------------------------------
`default_nettype none

module dset_checker
    import dset_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rsp_valid,
    input  wire logic                rsp_stall,
    input  wire logic [1:0]          status,
    input  wire logic                found,
    input  wire logic [DATE_W-1:0]   latest_date,
    input  wire logic [OUT_CNT_W-1:0] entry_count,
    input  wire logic [ID_W-1:0]     head_id,
    input  wire logic [DATE_W-1:0]   head_date
);

    // Count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (entry_count <= OUT_CNT_W'(TABLE_DEPTH)))
        else $error("entry count above table depth");

    // Empty table reports a zero head
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (entry_count == '0)) |-> ((head_id == '0) && (head_date == '0)))
        else $error("nonzero head on empty table");

    // Full and empty refusals agree with the count
    a_refusal_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && ((status == ST_FULL) || (status == ST_EMPTY))) |->
        (((status == ST_FULL) && (entry_count == OUT_CNT_W'(TABLE_DEPTH))) ||
         ((status == ST_EMPTY) && (entry_count == '0))))
        else $error("refusal status disagrees with count");

    // Found only with done status; absent id gives zero date
    a_lookup_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((!found || (status == ST_DONE)) &&
                       (found || (latest_date == '0))))
        else $error("lookup fields inconsistent with status");

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) &&
                                      $stable(entry_count) && $stable(head_date)))
        else $error("stalled response changed");

endmodule

bind date_sorted_entry_table dset_checker u_dset_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .found       (found),
    .latest_date (latest_date),
    .entry_count (entry_count),
    .head_id     (head_id),
    .head_date   (head_date)
);

`default_nettype wire

// File: verif/tb_date_sorted_entry_table.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_date_sorted_entry_table
// Self-checking bench for the date sorted entry table. Requests are sent with
// random gaps, and responses are taken with random stalls. A shadow copy of
// the table predicts each response when its request is accepted, and the
// prediction is compared field by field with what comes back. Directed
// tests cover the empty table, ordering and tie-breaks, and a full table.
// Random traffic then fills, drains and mixes the table.
// ---------------------------------------------------------------------------

module tb_date_sorted_entry_table;
    import dset_pkg::*;

    typedef struct packed {
        status_t                st;
        logic                   found;
        logic [DATE_W-1:0]      latest;
        logic [OUT_CNT_W-1:0]   count;
        logic [ID_W-1:0]        hid;
        logic [DATE_W-1:0]      hdate;
    } table_result_t;

    localparam int IDLE_LIMIT = 3000;
    localparam logic [DATE_W-1:0] DATE_MAX = '1;
    localparam logic [ID_W-1:0]   ID_MAX   = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [1:0]             mode = MODE_INSERT;
    logic [DATE_W-1:0]      date_key = '0;
    logic [ID_W-1:0]        entry_id = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic [1:0]             status;
    logic                   found;
    logic [DATE_W-1:0]      latest_date;
    logic [OUT_CNT_W-1:0]   entry_count;
    logic [ID_W-1:0]        head_id;
    logic [DATE_W-1:0]      head_date;

    // Shadow copy of the table, newest entry at index 0
    logic [DATE_W-1:0]      shadow_date [TABLE_DEPTH];
    logic [ID_W-1:0]        shadow_id [TABLE_DEPTH];
    int                     shadow_count = 0;

    table_result_t          pending_results[$];
    int                     error_count = 0;
    int                     idle_cycles = 0;
    int                     rsp_stall_left = 0;
    bit                     req_quiet = 1'b0;
    bit                     rsp_quiet = 1'b0;

    date_sorted_entry_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .date_key    (date_key),
        .entry_id    (entry_id),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .found       (found),
        .latest_date (latest_date),
        .entry_count (entry_count),
        .head_id     (head_id),
        .head_date   (head_date)
    );

    always #2 clk = ~clk;

    // Apply one request to the shadow table and return the response it gives
    function automatic table_result_t table_apply(input mode_t op,
                                                  input logic [DATE_W-1:0] d,
                                                  input logic [ID_W-1:0] id);
        table_result_t r;
        int pos;
        r.st = ST_DONE;
        r.found = 1'b0;
        r.latest = '0;
        case (op)
            MODE_INSERT:
            begin
                if (shadow_count >= TABLE_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    // skip past every entry that sorts ahead of the new one
                    pos = 0;
                    while (pos < shadow_count && (d < shadow_date[pos] ||
                           (d == shadow_date[pos] && id <= shadow_id[pos])))
                        pos++;
                    for (int k = shadow_count; k > pos; k--)
                    begin
                        shadow_date[k] = shadow_date[k-1];
                        shadow_id[k]   = shadow_id[k-1];
                    end
                    shadow_date[pos] = d;
                    shadow_id[pos]   = id;
                    shadow_count++;
                end
            end
            MODE_POP_FIRST:
            begin
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    for (int k = 0; k + 1 < shadow_count; k++)
                    begin
                        shadow_date[k] = shadow_date[k+1];
                        shadow_id[k]   = shadow_id[k+1];
                    end
                    shadow_count--;
                end
            end
            MODE_POP_LAST:
            begin
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else
                    shadow_count--;
            end
            default:
            begin
                // keep the newest date among all matching entries
                for (int k = 0; k < shadow_count; k++)
                begin
                    if (shadow_id[k] == id)
                    begin
                        if (!r.found || shadow_date[k] > r.latest)
                            r.latest = shadow_date[k];
                        r.found = 1'b1;
                    end
                end
                if (!r.found)
                    r.st = ST_ABSENT;
            end
        endcase
        r.count = OUT_CNT_W'(shadow_count);
        r.hid   = (shadow_count != 0) ? shadow_id[0] : '0;
        r.hdate = (shadow_count != 0) ? shadow_date[0] : '0;
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int draw_idle_len(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Favor ids already in the table so lookups and ties hit
    function automatic logic [ID_W-1:0] draw_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && shadow_count != 0)
            return shadow_id[$urandom_range(0, shadow_count - 1)];
        if (r < 70)
            return ID_W'($urandom_range(0, 7));
        if (r < 80)
            return ($urandom_range(0, 1) != 0) ? ID_MAX : '0;
        return ID_W'($urandom());
    endfunction

    function automatic logic [DATE_W-1:0] draw_date();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25 && shadow_count != 0)
            return shadow_date[$urandom_range(0, shadow_count - 1)];
        if (r < 50)
            return DATE_W'($urandom_range(0, 7));
        if (r < 60)
            return ($urandom_range(0, 1) != 0) ? DATE_MAX : '0;
        return $urandom();
    endfunction

    task automatic report_mismatch(input string what, input logic [DATE_W-1:0] got,
                                   input logic [DATE_W-1:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Send one request; called at a rising edge, returns at its acceptance edge
    task automatic send_request(input mode_t op, input logic [DATE_W-1:0] d,
                                input logic [ID_W-1:0] id);
        int gap;
        gap = draw_idle_len(req_quiet);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        mode      <= op;
        date_key  <= d;
        entry_id  <= id;
        do
            @(posedge clk);
        while (req_stall);
        pending_results.push_back(table_apply(op, d, id));
    endtask

    // Hold off new requests until every response is back
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Check each response against the oldest prediction, then pick the next stall
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("response with no request pending", DATE_W'(status), '0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", DATE_W'(status), DATE_W'(want.st));
                if (found !== want.found)
                    report_mismatch("found", DATE_W'(found), DATE_W'(want.found));
                if (latest_date !== want.latest)
                    report_mismatch("latest_date", latest_date, want.latest);
                if (entry_count !== want.count)
                    report_mismatch("entry_count", DATE_W'(entry_count),
                                    DATE_W'(want.count));
                if (head_id !== want.hid)
                    report_mismatch("head_id", DATE_W'(head_id), DATE_W'(want.hid));
                if (head_date !== want.hdate)
                    report_mismatch("head_date", head_date, want.hdate);
            end
        end
        if (rsp_stall_left > 0)
        begin
            rsp_stall_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall_left = draw_idle_len(rsp_quiet);
            rsp_stall <= (rsp_stall_left > 0);
            if (rsp_stall_left > 0)
                rsp_stall_left--;
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Removes and lookups on an empty table
    task automatic test_empty_table();
        send_request(MODE_POP_FIRST, DATE_MAX, ID_MAX);
        send_request(MODE_POP_LAST, '0, '0);
        send_request(MODE_LOOKUP, '0, '0);
        send_request(MODE_LOOKUP, '0, ID_MAX);
    endtask

    // Date order, id tie-breaks, duplicates and lookup of the newest date
    task automatic test_ordering();
        send_request(MODE_INSERT, 32'd5, 16'd10);
        send_request(MODE_INSERT, 32'd5, 16'd10);
        send_request(MODE_INSERT, 32'd5, 16'd11);
        send_request(MODE_INSERT, 32'd5, 16'd9);
        send_request(MODE_INSERT, '0, '0);
        send_request(MODE_INSERT, DATE_MAX, ID_MAX);
        send_request(MODE_INSERT, DATE_MAX, '0);
        send_request(MODE_INSERT, 32'hAAAA_5555, 16'h55AA);
        send_request(MODE_LOOKUP, '0, 16'd10);
        send_request(MODE_INSERT, 32'd7, 16'd10);
        send_request(MODE_LOOKUP, '0, 16'd10);
        send_request(MODE_LOOKUP, '0, 16'd12345);
        send_request(MODE_LOOKUP, '0, ID_MAX);
        send_request(MODE_POP_FIRST, '0, '0);
        send_request(MODE_POP_LAST, '0, '0);
        send_request(MODE_LOOKUP, '0, '0);
        send_request(MODE_POP_LAST, '0, '0);
        // drain what is left, one removal past empty
        while (shadow_count > 0)
            send_request(($urandom_range(0, 1) != 0) ? MODE_POP_FIRST : MODE_POP_LAST,
                         '0, '0);
        send_request(MODE_POP_FIRST, '0, '0);
    endtask

    // Fill to capacity, refuse inserts when full, then drain
    task automatic test_full_table();
        while (shadow_count < TABLE_DEPTH)
            send_request(MODE_INSERT, draw_date(), draw_id());
        send_request(MODE_INSERT, DATE_MAX, ID_MAX);
        send_request(MODE_INSERT, '0, '0);
        send_request(MODE_LOOKUP, '0, draw_id());
        send_request(MODE_POP_LAST, '0, '0);
        send_request(MODE_INSERT, DATE_MAX, ID_MAX);
        send_request(MODE_INSERT, draw_date(), draw_id());
        while (shadow_count > 0)
            send_request(($urandom_range(0, 3) != 0) ? MODE_POP_FIRST : MODE_POP_LAST,
                         '0, '0);
        send_request(MODE_POP_LAST, '0, '0);
    endtask

    // Stop sending until the table has answered everything, then resume
    task automatic test_pause_then_resume();
        req_quiet = 1'b1;
        repeat (10)
            send_request(($urandom_range(0, 2) != 0) ? MODE_INSERT : MODE_LOOKUP,
                         draw_date(), draw_id());
        wait_for_responses();
        repeat (10)
            send_request(mode_t'($urandom_range(0, 3)), draw_date(), draw_id());
        req_quiet = 1'b0;
    endtask

    // Phases that fill, drain or mix the table with random content
    task automatic test_random_traffic(input int total);
        int issued;
        int phase;
        int len;
        int ins_pct;
        int rem_pct;
        int r;
        mode_t op;
        issued = 0;
        phase = 0;
        while (issued < total)
        begin
            case (phase % 3)
                0:
                begin
                    ins_pct = 75;
                    rem_pct = 10;
                end
                1:
                begin
                    ins_pct = 15;
                    rem_pct = 65;
                end
                default:
                begin
                    ins_pct = 40;
                    rem_pct = 35;
                end
            endcase
            req_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
            len = $urandom_range(40, 120);
            repeat (len)
            begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    op = MODE_INSERT;
                else if (r < ins_pct + rem_pct)
                    op = ($urandom_range(0, 1) != 0) ? MODE_POP_FIRST : MODE_POP_LAST;
                else
                    op = MODE_LOOKUP;
                send_request(op, draw_date(), draw_id());
                issued++;
            end
            phase++;
        end
        req_quiet = 1'b0;
        rsp_quiet = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_ordering();
        test_full_table();
        test_pause_then_resume();
        test_random_traffic(530);
        wait_for_responses();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dset_pkg.sv
rtl/dset_ctrl.sv
rtl/dset_datapath.sv
rtl/date_sorted_entry_table.sv
rtl/dset_checker.sv
verif/tb_date_sorted_entry_table.sv
